// ----- hw/rtl/isort_pkg.sv -----
package isort_pkg;

   localparam int MAX_COUNT_DEF = 16;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_res;
      logic               last_res;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               valid;
   } cell_data_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

   localparam cell_data_type EMPTY_CELL = '{value: '0, valid: 1'b0};

endpackage

// ----- hw/rtl/isort_cell.sv -----
module isort_cell
   import isort_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic signed [31:0] new_value,
   input  cell_data_type      left,
   input  logic               left_gt,
   input  cell_data_type      right,
   output cell_data_type      cur,
   output logic               gt
);

   logic signed [31:0] value_ff, value_in;
   logic               valid_ff, valid_in;

   // empty cells count as larger than anything
   assign gt = !valid_ff || (value_ff > new_value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.drain) begin
         value_in = right.value;
         valid_in = right.valid;
      end else if (ctrl.insert && gt) begin
         if (left_gt) begin
            value_in = left.value;
            valid_in = left.valid;
         end else begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cur = '{value: value_ff, valid: valid_ff};

endmodule

// ----- hw/rtl/insertion_sorter.sv -----
// Channel  Dir  Beat      Handshake
// req      in   req_type  req_valid / req_stall
// rsp      out  rsp_type  rsp_valid / rsp_stall
//
// Unless stalled or full, one value is inserted per cycle: each cell compares
// the new value in parallel, shifting one place right if it holds a larger one.
// A last-marked beat starts the drain, which shifts the chain left one cell per
// taken rsp beat; req_stall stays high for those n beats (n = stored entries).
// Reset clears all cell valid bits, the drain flag and the overflow flag.
// A stalled rsp beat holds the chain and its payload unchanged.
module insertion_sorter
   import isort_pkg::*;
#(
   parameter int MAX_COUNT = MAX_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   cell_data_type cells [MAX_COUNT];
   logic          gts   [MAX_COUNT];
   cell_ctrl_type ctrl;

   logic drain_ff, drain_in;
   logic dropped_ff, dropped_in;
   logic req_take, rsp_take, full, final_beat;

   assign req_stall  = drain_ff;
   assign req_take   = req_valid && !req_stall;
   assign full       = cells[MAX_COUNT-1].valid;
   assign rsp_take   = drain_ff && !rsp_stall;
   assign final_beat = !cells[1].valid;

   assign ctrl.insert = req_take && !full;
   assign ctrl.drain  = rsp_take;

   for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
      cell_data_type left_d, right_d;
      logic          left_g;
      if (i == 0) begin : g_first
         assign left_d = EMPTY_CELL;
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_d = cells[i-1];
         assign left_g = gts[i-1];
      end
      if (i == MAX_COUNT - 1) begin : g_end
         assign right_d = EMPTY_CELL;
      end else begin : g_inner
         assign right_d = cells[i+1];
      end
      isort_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_value (req.value),
         .left      (left_d),
         .left_gt   (left_g),
         .right     (right_d),
         .cur       (cells[i]),
         .gt        (gts[i])
      );
   end

   always_comb begin
      drain_in   = drain_ff;
      dropped_in = dropped_ff;
      if (rsp_take && final_beat) begin
         drain_in   = 1'b0;
         dropped_in = 1'b0;
      end
      if (req_take) begin
         drain_in = req.last;
         if (full) begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff   <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         drain_ff   <= drain_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_valid     = drain_ff;
   assign rsp.value_res = cells[0].value;
   assign rsp.last_res  = final_beat;
   assign rsp.overflow  = dropped_ff;

endmodule
